// ----- rtl/lgs_pkg.sv -----
package lgs_pkg;

  // Register and counter widths fixed by the register file.
  localparam int CFG_W      = 9;
  localparam int CFG_ADDR_W = 8;
  localparam int K_W        = 2 * CFG_W;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int RESET_SIZE     = 256;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = CFG_ADDR_W'(1);

  // Input item codes.
  localparam logic FUNC_CELL  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Control carried from the address stage to the window stage.
  typedef struct packed {
    logic valid;
    logic cell_bit;
    logic res_due;
    logic left_edge;
    logic right_edge;
    logic top_edge;
    logic bottom_edge;
    logic last;
  } lgs_s1_t;

  // A size of zero acts as one, a size above the maximum as the maximum.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int unsigned max_v);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > max_v) begin
      res = CFG_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- rtl/lgs_in_if.sv -----
interface lgs_in_if;
  logic valid;
  logic ready;
  logic func;
  logic alive;

  modport source (output valid, output func, output alive, input ready);
  modport sink   (input valid, input func, input alive, output ready);
endinterface

// ----- rtl/lgs_out_if.sv -----
interface lgs_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic frame_last;

  modport source (output valid, output next_alive, output frame_last, input ready);
  modport sink   (input valid, input next_alive, input frame_last, output ready);
endinterface

// ----- rtl/lgs_cfg_if.sv -----
interface lgs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lgs_pkg::CFG_ADDR_W-1:0]    addr;
  logic [lgs_pkg::CFG_W-1:0]         data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- rtl/lgs_ram.sv -----
module lgs_ram #(
  parameter int DATA_W = 2,
  parameter int DEPTH  = 256
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [DATA_W-1:0]          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [DATA_W-1:0]          rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lgs_ctrl.sv -----
module lgs_ctrl #(
  parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lgs_in_if.sink                        in_ch,
  lgs_cfg_if.sink                       cfg_ch,
  input  logic                          advance,
  output logic                          cfg_restart,
  output logic                          rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output lgs_pkg::lgs_s1_t              s1,
  output logic [$clog2(MAX_WIDTH)-1:0]  s1_addr
);
  import lgs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [CFG_W-1:0] RST_W = clamp_size(CFG_W'(RESET_SIZE), MAX_WIDTH);
  localparam logic [CFG_W-1:0] RST_H = clamp_size(CFG_W'(RESET_SIZE), MAX_HEIGHT);
  localparam logic [K_W-1:0]   RST_TOTAL = K_W'(RST_W) * K_W'(RST_H);

  logic [CFG_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [K_W-1:0]   total_r, total_nxt;
  logic [CFG_W-1:0] in_col_r, in_col_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CFG_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  lgs_s1_t          s1_r, s1_nxt;
  logic [AW-1:0]    s1_addr_r, s1_addr_nxt;

  logic accept, received_lt, shift, res_due, last, col_wrap, out_wrap;
  logic left_edge, right_edge, top_edge, bottom_edge;
  logic cfg_hit;
  logic [CFG_W-1:0] cfg_size;

  assign in_ch.ready  = advance;
  assign cfg_ch.ready = 1'b1;
  assign cfg_restart  = cfg_hit;

  always_comb begin
    accept      = in_ch.valid && advance;
    received_lt = k_r < total_r;
    // Early flushes are dropped; late cells shift in as dead.
    shift       = accept && !(received_lt && (in_ch.func == FUNC_FLUSH));
    res_due     = k_r > K_W'(w_r);
    left_edge   = out_col_r == '0;
    right_edge  = out_col_r == w_r - CFG_W'(1);
    top_edge    = out_row_r == '0;
    bottom_edge = out_row_r == h_r - CFG_W'(1);
    last        = res_due && right_edge && bottom_edge;
    col_wrap    = in_col_r == w_r - CFG_W'(1);
    out_wrap    = right_edge;
    // Writes to indexes other than the two size registers have no effect.
    cfg_hit     = cfg_ch.valid &&
                  ((cfg_ch.addr == REG_GRID_WIDTH) || (cfg_ch.addr == REG_GRID_HEIGHT));
    cfg_size    = clamp_size(cfg_ch.data,
                             (cfg_ch.addr == REG_GRID_WIDTH) ? MAX_WIDTH : MAX_HEIGHT);

    w_nxt       = w_r;
    h_nxt       = h_r;
    total_nxt   = total_r;
    in_col_nxt  = in_col_r;
    k_nxt       = k_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    if (cfg_hit) begin
      if (cfg_ch.addr == REG_GRID_WIDTH) begin
        w_nxt     = cfg_size;
        total_nxt = K_W'(cfg_size) * K_W'(h_r);
      end else begin
        h_nxt     = cfg_size;
        total_nxt = K_W'(w_r) * K_W'(cfg_size);
      end
      in_col_nxt  = '0;
      k_nxt       = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (shift) begin
      in_col_nxt = col_wrap ? '0 : in_col_r + CFG_W'(1);
      k_nxt      = k_r + K_W'(1);
      if (res_due) begin
        out_col_nxt = out_wrap ? '0 : out_col_r + CFG_W'(1);
        out_row_nxt = out_wrap ? out_row_r + CFG_W'(1) : out_row_r;
      end
      if (last) begin
        in_col_nxt  = '0;
        k_nxt       = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end

    s1_nxt      = s1_r;
    s1_addr_nxt = s1_addr_r;
    if (advance) begin
      s1_nxt.valid       = shift;
      s1_nxt.cell_bit    = received_lt ? in_ch.alive : 1'b0;
      s1_nxt.res_due     = res_due;
      s1_nxt.left_edge   = left_edge;
      s1_nxt.right_edge  = right_edge;
      s1_nxt.top_edge    = top_edge;
      s1_nxt.bottom_edge = bottom_edge;
      s1_nxt.last        = last;
      s1_addr_nxt        = AW'(in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= RST_W;
      h_r       <= RST_H;
      total_r   <= RST_TOTAL;
      in_col_r  <= '0;
      k_r       <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_r      <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      total_r   <= total_nxt;
      in_col_r  <= in_col_nxt;
      k_r       <= k_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      s1_r      <= s1_nxt;
    end
    s1_addr_r <= s1_addr_nxt;
  end

  assign rd_en   = shift;
  assign rd_addr = AW'(in_col_r);
  assign s1      = s1_r;
  assign s1_addr = s1_addr_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < w_r)
    else $error("input column beyond grid width");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    shift && last |=> (k_r == '0) && (out_col_r == '0) && (out_row_r == '0))
    else $error("frame not restarted after last result");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.valid && !advance |=> s1_r.valid && $stable(s1_addr_r))
    else $error("stalled window stage item lost");

endmodule

// ----- rtl/lgs_window.sv -----
module lgs_window #(
  parameter int MAX_WIDTH = lgs_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_restart,
  input  lgs_pkg::lgs_s1_t              s1,
  input  logic [$clog2(MAX_WIDTH)-1:0]  s1_addr,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic [1:0]                    ram_rd_data,
  output logic                          ram_wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  ram_wr_addr,
  output logic [1:0]                    ram_wr_data,
  output logic                          advance,
  lgs_out_if.source                     out_ch
);
  import lgs_pkg::*;

  logic [8:0] win_r, win_nxt, win_new;
  logic       fwd_r, fwd_nxt;
  logic [1:0] fwd_data_r, fwd_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_alive_r, out_alive_nxt;
  logic       out_last_r, out_last_nxt;

  logic       proc, above, mid, center;
  logic [1:0] col_bits;
  logic [8:0] mask;
  logic [3:0] count;

  always_comb begin
    advance = !out_valid_r || out_ch.ready;
    proc    = s1.valid && advance;

    // Entry [0] is the row above, [1] the middle row.
    col_bits = fwd_r ? fwd_data_r : ram_rd_data;
    above    = col_bits[0];
    mid      = col_bits[1];
    win_new  = {s1.cell_bit, mid, above, win_r[8:3]};

    // Bit j*3+i: column j (0 = left), row i (0 = above).
    mask = 9'b111_101_111;
    if (s1.left_edge) begin
      mask[2:0] = 3'b000;
    end
    if (s1.right_edge) begin
      mask[8:6] = 3'b000;
    end
    if (s1.top_edge) begin
      mask[0] = 1'b0;
      mask[3] = 1'b0;
      mask[6] = 1'b0;
    end
    if (s1.bottom_edge) begin
      mask[2] = 1'b0;
      mask[5] = 1'b0;
      mask[8] = 1'b0;
    end
    count  = 4'($countones(win_new & mask));
    center = win_new[4];

    win_nxt = win_r;
    if (cfg_restart) begin
      win_nxt = '0;
    end else if (proc) begin
      win_nxt = s1.last ? '0 : win_new;
    end

    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    if (rd_en) begin
      fwd_nxt      = proc && (rd_addr == s1_addr);
      fwd_data_nxt = {s1.cell_bit, mid};
    end

    out_valid_nxt = out_valid_r;
    out_alive_nxt = out_alive_r;
    out_last_nxt  = out_last_r;
    if (proc && s1.res_due) begin
      out_valid_nxt = 1'b1;
      out_alive_nxt = center ? ((count == 4'd2) || (count == 4'd3)) : (count == 4'd3);
      out_last_nxt  = s1.last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fwd_data_r  <= fwd_data_nxt;
    out_alive_r <= out_alive_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign ram_wr_en     = proc;
  assign ram_wr_addr   = s1_addr;
  assign ram_wr_data   = {s1.cell_bit, mid};
  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_alive = out_alive_r;
  assign out_ch.frame_last = out_last_r;

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1.valid && s1.last |-> s1.res_due)
    else $error("frame end marked on an item without a result");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1.last |=> win_r == '0)
    else $error("window not cleared at frame end");

endmodule

// ----- rtl/life_generation_stencil_unit.sv -----
//  Channel   Direction  Beat contents             Handshake
//  in_ch     in         func, alive               valid/ready
//  out_ch    out        next_alive, frame_last    valid/ready
//  cfg_ch    in         addr, data (9 bits)       valid/ready, ready always high
//
//  One input beat is taken per cycle while the result register is free or being
//  drained; the window stage registers each result behind the address stage.
//  The rate is set by the single two-bit line store port pair: one read and one
//  write per cycle. rst_n is synchronous and active low; the line store is not
//  cleared, since entries read before being written only feed masked border cells.
//  A stall on out_ch holds the whole pipeline and drops in_ch.ready.

module life_generation_stencil_unit #(
  parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  lgs_in_if.sink     in_ch,
  lgs_out_if.source  out_ch,
  lgs_cfg_if.sink    cfg_ch
);
  import lgs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // The design is a two-stage pipeline around one line store. The address stage
  // (lgs_ctrl) tracks the raster position of the input and of the next result,
  // decides whether a beat shifts a cell, and issues the line store read for the
  // column. The window stage (lgs_window) receives the two stored cells of that
  // column from the registered read, writes back the shifted column, slides the 3x3 window
  // and evaluates the birth/survival rule with the border mask.

  logic             advance;
  logic             cfg_restart;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  lgs_s1_t          s1;
  logic [AW-1:0]    s1_addr;
  logic [1:0]       ram_rd_data;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [1:0]       ram_wr_data;

  lgs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .advance     (advance),
    .cfg_restart (cfg_restart),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1          (s1),
    .s1_addr     (s1_addr)
  );

  // Each entry holds the row above in bit 0 and the middle row in bit 1 for one
  // column. With a one-column grid the read and the write-back hit the same
  // entry in the same cycle; the window stage forwards the written value then.
  lgs_ram #(
    .DATA_W (2),
    .DEPTH  (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  lgs_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_restart (cfg_restart),
    .s1          (s1),
    .s1_addr     (s1_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .advance     (advance),
    .out_ch      (out_ch)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lgs_pkg::*;

  // One input beat: a cell of the current generation or a flush.
  typedef struct packed {
    logic func;
    logic alive;
  } cell_beat_t;

  // One result beat: the next state of a cell in raster order.
  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } cell_result_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned GRID_CELLS  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();
  lgs_cfg_if cfg_ch ();

  life_generation_stencil_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Beats waiting for the driver, and next states that the monitor still awaits.
  cell_beat_t   pending_beats[$];
  cell_result_t expected_cells[$];

  // Our own copy of the block's settings and frame position.
  logic [CFG_W-1:0] width_setting  = CFG_W'(RESET_SIZE);
  logic [CFG_W-1:0] height_setting = CFG_W'(RESET_SIZE);
  bit               frame_cells [GRID_CELLS];
  int unsigned      cells_in     = 0;
  int unsigned      results_out  = 0;

  int unsigned mismatches      = 0;
  int unsigned beats_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed   = 0;
  int unsigned settings_used   = 0;
  int unsigned counted_beats   = 0;
  int unsigned cycle_count     = 0;

  // Idle odds: zero means no idling, otherwise one chance in N per beat.
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  // A register value of zero acts as one; anything past the maximum is clipped.
  function automatic int unsigned cells_in_use(input logic [CFG_W-1:0] reg_val,
                                               input int unsigned limit);
    int unsigned v;
    v = reg_val;
    if (v == 0) v = 1;
    if (v > limit) v = limit;
    return v;
  endfunction

  // Applies one accepted input beat to the frame and queues the next state it
  // releases, if any. The result for cell o is due once the cell one row and
  // one column past it has arrived, so all eight neighbors are known by then.
  task automatic step_life_model(input cell_beat_t beat);
    int unsigned  w, h, total, k, o, orow, ocol, count;
    int           r, c;
    cell_result_t res;
    w     = cells_in_use(width_setting, DEF_MAX_WIDTH);
    h     = cells_in_use(height_setting, DEF_MAX_HEIGHT);
    total = w * h;
    k     = cells_in;
    // A flush before the frame is complete is dropped without a trace.
    if (k < total && beat.func == FUNC_FLUSH) return;
    // Past the end of the grid every beat shifts in a dead virtual cell.
    if (k < total) frame_cells[k] = beat.alive;
    cells_in++;
    if (k < w + 1 || results_out >= total) return;
    o     = results_out;
    orow  = o / w;
    ocol  = o % w;
    count = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = int'(orow) + dr;
        c = int'(ocol) + dc;
        // Fixed borders: anything outside the grid counts as dead.
        if ((dr != 0 || dc != 0) && r >= 0 && c >= 0 && r < int'(h) && c < int'(w))
          count += frame_cells[r * int'(w) + c];
      end
    end
    res.next_alive = frame_cells[o] ? (count == 2 || count == 3) : (count == 3);
    res.frame_last = (o + 1 == total);
    results_out++;
    if (res.frame_last) begin
      cells_in    = 0;
      results_out = 0;
    end
    expected_cells.push_back(res);
  endtask

  // Driver: holds a beat until it is taken, then presents the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_life_model(pending_beats.pop_front());
        beats_taken++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.func  <= pending_beats[0].func;
          in_ch.alive <= pending_beats[0].alive;
        end
      end
    end
  end

  // Monitor: checks every result beat against the oldest expectation and
  // stalls the result channel in random bursts.
  always @(posedge clk) begin
    cell_result_t exp_cell;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got next_alive=%b frame_last=%b",
                   $time, out_ch.next_alive, out_ch.frame_last);
        end else begin
          exp_cell = expected_cells.pop_front();
          if (out_ch.next_alive !== exp_cell.next_alive) begin
            mismatches++;
            $display("%0t: next_alive of result %0d: expected %b, got %b",
                     $time, results_checked, exp_cell.next_alive, out_ch.next_alive);
          end
          if (out_ch.frame_last !== exp_cell.frame_last) begin
            mismatches++;
            $display("%0t: frame_last of result %0d: expected %b, got %b",
                     $time, results_checked, exp_cell.frame_last, out_ch.frame_last);
          end
          if (exp_cell.frame_last) frames_closed++;
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Waits until every queued beat is taken and every expected result has come,
  // then gives the two-stage pipeline time to finish anything that gives no result.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_cells.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // A write to either size register also restarts the frame; the line store keeps its data.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_setting = CFG_W'(val);
    else height_setting = CFG_W'(val);
    cells_in    = 0;
    results_out = 0;
    settings_used++;
  endtask

  task automatic add_beat(input logic func, input logic alive);
    cell_beat_t b;
    b.func  = func;
    b.alive = alive;
    pending_beats.push_back(b);
  endtask

  // Queues one frame at the current size with a random density, broken off
  // after 'cut' cells when cut is below the cell count. Stray early flushes
  // are sprinkled in, and a whole frame ends in a tail of flushes and extra cells.
  task automatic send_frame(input int unsigned cut);
    int unsigned w, total, density;
    w       = cells_in_use(width_setting, DEF_MAX_WIDTH);
    total   = w * cells_in_use(height_setting, DEF_MAX_HEIGHT);
    density = $urandom_range(10, 90);
    for (int unsigned i = 0; i < total; i++) begin
      if (i == cut) return;
      if ($urandom_range(0, 19) == 0) add_beat(FUNC_FLUSH, 1'($urandom_range(0, 1)));
      add_beat(FUNC_CELL, $urandom_range(0, 99) < density);
      counted_beats++;
      // Now and then the sender waits mid-frame for every result to drain.
      if (i == total / 2 && $urandom_range(0, 7) == 0) wait_idle();
    end
    for (int unsigned j = 0; j <= w; j++) begin
      add_beat($urandom_range(0, 1) ? FUNC_FLUSH : FUNC_CELL, 1'($urandom_range(0, 1)));
      counted_beats++;
    end
  endtask

  initial begin
    int unsigned start_count, nframes, total;
    bit          quiet_tail;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_CELL;
    in_ch.alive  = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = REG_GRID_WIDTH;
    cfg_ch.data  = '0;
    quiet_tail   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // At the reset size a flush is too early, and a few cells release nothing.
    add_beat(FUNC_FLUSH, 1'b1);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_CELL, 1'b0);
    add_beat(FUNC_CELL, 1'b1);
    wait_idle();

    // Three by two grid: an early flush, a T-shaped pattern, a pause in the
    // middle of the frame, then an extra live cell that must act as a flush.
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 2);
    add_beat(FUNC_FLUSH, 1'b0);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_CELL, 1'b1);
    wait_idle();
    add_beat(FUNC_CELL, 1'b0);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_CELL, 1'b0);
    add_beat(FUNC_CELL, 1'b1);
    repeat (3) add_beat(FUNC_FLUSH, 1'b1);
    wait_idle();

    // Zero sizes act as a single cell, which always dies alone.
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 0);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_CELL, 1'b1);
    add_beat(FUNC_FLUSH, 1'b0);
    wait_idle();

    // A frame abandoned halfway and restarted by rewriting the same width.
    write_reg(REG_GRID_WIDTH, 4);
    write_reg(REG_GRID_HEIGHT, 3);
    repeat (6) add_beat(FUNC_CELL, 1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(REG_GRID_WIDTH, 4);
    send_frame(12);
    wait_idle();

    // Oversized widths and heights clip to the maximum. A 300-wide grid must
    // release its first results once one row of 256 cells and a bit more have
    // arrived; that frame is then abandoned. A 511-high column ends at 256 cells.
    gap_odds   = 6;
    stall_odds = 6;
    write_reg(REG_GRID_WIDTH, 300);
    write_reg(REG_GRID_HEIGHT, 2);
    send_frame(DEF_MAX_WIDTH + 3);
    wait_idle();
    write_reg(REG_GRID_WIDTH, 1);
    write_reg(REG_GRID_HEIGHT, 511);
    send_frame(GRID_CELLS);
    wait_idle();

    // Random part: mostly small grids, whole frames back to back, sometimes
    // a broken-off frame that the next register write restarts.
    start_count = counted_beats;
    while (counted_beats - start_count < 120) begin
      wait_idle();
      if (!quiet_tail && counted_beats - start_count > 90) begin
        quiet_tail = 1'b1;
        gap_odds   = 0;
        stall_odds = 0;
      end else if (!quiet_tail) begin
        gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
        stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_GRID_WIDTH, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1)
                                 : ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                               : $urandom_range(2, 8));
      if ($urandom_range(0, 3) != 0 || settings_used == 0)
        write_reg(REG_GRID_HEIGHT, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1)
                                  : ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                                : $urandom_range(2, 8));
      else
        write_reg(REG_GRID_HEIGHT, height_setting);
      total   = cells_in_use(width_setting, DEF_MAX_WIDTH)
              * cells_in_use(height_setting, DEF_MAX_HEIGHT);
      nframes = $urandom_range(1, 3);
      for (int unsigned f = 0; f < nframes; f++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_frame($urandom_range(0, total - 1));
          break;
        end
        send_frame(total);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d input beats over %0d register writes.",
             results_checked, beats_taken, settings_used);
    $display("Closed %0d frames, grid sizes from 1x1 up to 256 wide and 256 high.",
             frames_closed);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
